// ----- hw/rtl/mlp_backprop_trainer_top_defines.svh -----
// Assertion macros used by the checker file of the trainer.
`ifndef MLP_BACKPROP_TRAINER_TOP_DEFINES_SVH
`define MLP_BACKPROP_TRAINER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define MBT_ASSERT_IMP(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("mbt check failed");

// Condition must hold in the cycle after the trigger.
`define MBT_ASSERT_NXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("mbt check failed");

`endif

// ----- hw/rtl/mbt_pkg.sv -----
package mbt_pkg;

  // Network shape.
  localparam int IN_CNT  = 4;
  localparam int HID_W   = 4;
  localparam int HID_D   = 3;
  localparam int OUT_CNT = 3;

  // Fields present on the channels.
  localparam int FEAT_N  = 4;
  localparam int SCORE_N = 3;

  localparam int MAX_FI = (IN_CNT > HID_W) ? IN_CNT : HID_W;
  localparam int MAX_N  = (MAX_FI > OUT_CNT) ? MAX_FI : OUT_CNT;

  // Flat weight layout: layer-major, then neuron, fan-in weights then bias.
  localparam int HBASE   = HID_W * (IN_CNT + 1);
  localparam int HSTRIDE = HID_W * (HID_W + 1);
  localparam int W_TOTAL = HBASE + (HID_D - 1) * HSTRIDE + OUT_CNT * (HID_W + 1);

  localparam int WA_W   = $clog2(W_TOTAL);
  localparam int LAY_W  = $clog2(HID_D + 2);
  localparam int NRN_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int TAP_W  = $clog2(MAX_FI + 1);
  localparam int ACT_N  = (HID_D + 2) * MAX_N;
  localparam int ACT_IW = $clog2(ACT_N);
  localparam int DLT_N  = (HID_D + 1) * MAX_N;
  localparam int DLT_IW = $clog2(DLT_N);

  // Data widths.
  localparam int W_W   = 16;
  localparam int ACT_W = 17;
  localparam int Q_W   = 11;
  localparam int LR_W  = 11;
  localparam int MA_W  = 28;
  localparam int MB_W  = 17;
  localparam int PR_W  = MA_W + MB_W;

  localparam int ONE_Q10 = 1024;
  localparam logic [LR_W-1:0] LR_RESET = 11'd51;

  // Action codes.
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  typedef logic [255:0][Q_W-1:0] sig_lut_t;

  // Unsigned restoring division, used only while the table is built.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table over [-8, 8) in steps of 1/16, built from an exp recurrence.
  function automatic sig_lut_t build_sig_lut();
    sig_lut_t lut;
    longint unsigned e;
    longint unsigned den;
    longint unsigned step;
    lut  = '0;
    e    = 64'd1 << 30;
    step = 64'd1142992222;
    for (int j = 0; j <= 128; j++) begin
      den = e + (64'd1 << 30);
      if (128 + j < 256) begin
        lut[128 + j] = Q_W'(udiv64(64'd1024 * e + (den >> 1), den));
      end
      if (j > 0) begin
        lut[128 - j] = Q_W'(udiv64((64'd1 << 40) + (den >> 1), den));
      end
      e = (e >> 30) * step + (((e & 64'h3FFF_FFFF) * step + (64'd1 << 29)) >> 30);
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [W_W-1:0] sat16(input logic signed [PR_W:0] v);
    logic signed [W_W-1:0] r;
    if (v > $signed((PR_W+1)'(32767))) begin
      r = 16'sh7FFF;
    end else if (v < -$signed((PR_W+1)'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[W_W-1:0];
    end
    return r;
  endfunction

  // Round half up by ten fraction bits, then saturate.
  function automatic logic signed [W_W-1:0] rnd10_sat(input logic signed [PR_W-1:0] v);
    logic signed [PR_W:0] t;
    t = $signed({v[PR_W-1], v}) + $signed((PR_W+1)'(512));
    t = t >>> 10;
    return sat16(t);
  endfunction

  // Table sigmoid with saturation outside [-8, 8).
  function automatic logic [Q_W-1:0] sig_q10(input logic signed [W_W-1:0] z);
    logic [W_W-1:0] u;
    logic [Q_W-1:0] r;
    u = W_W'(z + 16'sd8192);
    if (z < -16'sd8192) begin
      r = SIG_LUT[0];
    end else if (z >= 16'sd8192) begin
      r = Q_W'(ONE_Q10);
    end else begin
      r = SIG_LUT[u[13:6]];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mbt_in_if.sv -----
interface mbt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] feature_a;
  logic signed [15:0] feature_b;
  logic signed [15:0] feature_c;
  logic signed [15:0] feature_d;
  logic [10:0]        target_a;
  logic [10:0]        target_b;
  logic [10:0]        target_c;
  logic [6:0]         weight_index;
  logic signed [15:0] weight_value;

  modport source (
    output valid, action, feature_a, feature_b, feature_c, feature_d,
    output target_a, target_b, target_c, weight_index, weight_value,
    input  ready
  );
  modport sink (
    input  valid, action, feature_a, feature_b, feature_c, feature_d,
    input  target_a, target_b, target_c, weight_index, weight_value,
    output ready
  );
endinterface

// ----- hw/rtl/mbt_out_if.sv -----
interface mbt_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] score_a;
  logic [10:0] score_b;
  logic [10:0] score_c;

  modport source (output valid, score_a, score_b, score_c, input ready);
  modport sink (input valid, score_a, score_b, score_c, output ready);
endinterface

// ----- hw/rtl/mlp_backprop_trainer_top.sv -----
// Sequence: a weight write is stored when accepted; inference runs the forward pass; training
// adds back-propagated terms and an update per weight (read, multiply, write-back).
// Throughput: one item at a time, bound by the single shared multiplier and the single read
// port of the weight memory, which every multiply-accumulate goes through.
// Reset (synchronous, active low): all weights read as zero through per-entry valid
// flags, learning rate returns to 51, the block is idle and no result is pending.
module mlp_backprop_trainer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  mbt_in_if.sink                    in_if,
  mbt_out_if.source                 out_if,
  input  logic                      cfg_wr_en,
  input  logic [mbt_pkg::LR_W-1:0]  cfg_wr_data
);
  import mbt_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_F_RD   = 14'b00000000000010,
    S_F_MAC  = 14'b00000000000100,
    S_F_ACT  = 14'b00000000001000,
    S_O_D1   = 14'b00000000010000,
    S_O_D2   = 14'b00000000100000,
    S_H_RD   = 14'b00000001000000,
    S_H_MAC  = 14'b00000010000000,
    S_H_D1   = 14'b00000100000000,
    S_H_D2   = 14'b00001000000000,
    S_U_RD   = 14'b00010000000000,
    S_U_MUL  = 14'b00100000000000,
    S_U_WR   = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [LR_W-1:0]          lr_r;
  logic [1:0]               op_r;
  logic [Q_W-1:0]           tgt_r [SCORE_N];
  logic [LAY_W-1:0]         lay_r;
  logic [NRN_W-1:0]         nrn_r;
  logic [TAP_W-1:0]         tap_r;
  logic [WA_W-1:0]          waddr_r;
  logic signed [PR_W-1:0]   acc_r;
  logic signed [W_W-1:0]    deriv_r;
  logic signed [W_W-1:0]    err_r;
  logic signed [MA_W-1:0]   step_r;
  logic signed [PR_W-1:0]   prod_r;
  logic signed [ACT_W-1:0]  act_r [ACT_N];
  logic signed [W_W-1:0]    dlt_r [DLT_N];
  logic signed [W_W-1:0]    mem [W_TOTAL];
  logic                     vld_r [W_TOTAL];
  logic signed [W_W-1:0]    rd_data_r;
  logic                     rd_vld_r;
  logic                     out_valid_r;
  logic [Q_W-1:0]           score_r [SCORE_N];

  logic                     accept;
  logic signed [W_W-1:0]    feat [FEAT_N];
  logic [Q_W-1:0]           tgt_in [SCORE_N];
  logic [TAP_W-1:0]         fan_in;
  logic [NRN_W-1:0]         last_nrn;
  logic [TAP_W-1:0]         last_k;
  logic                     tap_end;
  logic signed [W_W-1:0]    wgt;
  logic [LAY_W-1:0]         act_lay;
  logic [NRN_W-1:0]         act_n;
  logic [ACT_IW-1:0]        act_idx;
  logic signed [ACT_W-1:0]  act_rd;
  logic [DLT_IW-1:0]        dlt_idx;
  logic signed [W_W-1:0]    dlt_rd;
  logic [WA_W-1:0]          rd_addr;
  logic                     mem_we;
  logic [WA_W-1:0]          mem_wa;
  logic signed [W_W-1:0]    mem_wd;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PR_W-1:0]   prod;
  logic signed [W_W-1:0]    z_net;
  logic signed [W_W-1:0]    tgt_k;
  logic signed [PR_W:0]     upd_t;
  logic signed [PR_W:0]     upd_sum;
  logic                     out_free;

  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_if.ready;

  assign feat[0] = in_if.feature_a;
  assign feat[1] = in_if.feature_b;
  assign feat[2] = in_if.feature_c;
  assign feat[3] = in_if.feature_d;
  assign tgt_in[0] = in_if.target_a;
  assign tgt_in[1] = in_if.target_b;
  assign tgt_in[2] = in_if.target_c;

  // Layer geometry for the current counters.
  assign fan_in   = (lay_r == '0) ? TAP_W'(IN_CNT) : TAP_W'(HID_W);
  assign last_nrn = (lay_r == LAY_W'(HID_D)) ? NRN_W'(OUT_CNT - 1) : NRN_W'(HID_W - 1);
  assign last_k   = (lay_r == LAY_W'(HID_D - 1)) ? TAP_W'(OUT_CNT - 1) : TAP_W'(HID_W - 1);
  assign tap_end  = (tap_r == fan_in);

  // An entry never written reads as zero.
  assign wgt = rd_vld_r ? rd_data_r : '0;

  // Activation read port.
  always_comb begin
    if (state_r == S_O_D1 || state_r == S_O_D2 || state_r == S_H_D1) begin
      act_lay = LAY_W'(lay_r + 1'b1);
      act_n   = nrn_r;
    end else begin
      act_lay = lay_r;
      act_n   = NRN_W'(tap_r);
    end
  end
  assign act_idx = ACT_IW'(int'(act_lay) * MAX_N + int'(act_n));
  assign act_rd  = act_r[act_idx];

  // Delta read port.
  assign dlt_idx = (state_r == S_H_MAC) ?
                   DLT_IW'((int'(lay_r) + 1) * MAX_N + int'(tap_r)) :
                   DLT_IW'(int'(lay_r) * MAX_N + int'(nrn_r));
  assign dlt_rd  = dlt_r[dlt_idx];

  // Weight memory address: flat counter, or the fan-out weight when propagating back.
  assign rd_addr = (state_r == S_H_RD) ?
                   WA_W'(HBASE + int'(lay_r) * HSTRIDE + int'(tap_r) * (HID_W + 1)
                         + int'(nrn_r)) :
                   waddr_r;

  // Shared multiplier operand selection.
  assign tgt_k = (int'(nrn_r) < SCORE_N) ? $signed({5'b0, tgt_r[nrn_r]}) : act_rd[W_W-1:0];
  always_comb begin
    case (state_r)
      S_F_MAC: begin
        mul_a = MA_W'(wgt);
        mul_b = tap_end ? MB_W'(ONE_Q10) : act_rd;
      end
      S_O_D1, S_H_D1: begin
        mul_a = MA_W'(act_rd);
        mul_b = MB_W'($signed(ACT_W'(ONE_Q10)) - act_rd);
      end
      S_O_D2: begin
        mul_a = MA_W'(tgt_k) - MA_W'(act_rd);
        mul_b = MB_W'(deriv_r);
      end
      S_H_MAC: begin
        mul_a = MA_W'(dlt_rd);
        mul_b = MB_W'(wgt);
      end
      S_H_D2: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(deriv_r);
      end
      S_U_RD: begin
        mul_a = MA_W'($signed({1'b0, lr_r}));
        mul_b = MB_W'(dlt_rd);
      end
      S_U_MUL: begin
        mul_a = step_r;
        mul_b = tap_end ? MB_W'(ONE_Q10) : act_rd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign z_net = rnd10_sat(acc_r);

  // Weight update: round the scaled gradient by twenty bits and add.
  assign upd_t   = ($signed({prod_r[PR_W-1], prod_r}) + $signed((PR_W+1)'(524288))) >>> 20;
  assign upd_sum = upd_t + (PR_W+1)'(wgt);

  // Memory write port: item writes and update write-back.
  always_comb begin
    if (state_r == S_U_WR) begin
      mem_we = 1'b1;
      mem_wa = waddr_r;
      mem_wd = sat16(upd_sum);
    end else begin
      mem_we = accept && (in_if.action == OP_WRITE) && (32'(in_if.weight_index) < W_TOTAL);
      mem_wa = WA_W'(in_if.weight_index);
      mem_wd = in_if.weight_value;
    end
  end

  // Weight memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  // Per-entry written flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < W_TOTAL; k++) vld_r[k] <= 1'b0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_if.action == OP_WRITE) ? S_FINISH : S_F_RD;
        end
      end
      S_F_RD:  state_nxt = S_F_MAC;
      S_F_MAC: state_nxt = tap_end ? S_F_ACT : S_F_RD;
      S_F_ACT: begin
        if (nrn_r == last_nrn && lay_r == LAY_W'(HID_D)) begin
          state_nxt = (op_r == OP_TRAIN) ? S_O_D1 : S_FINISH;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_O_D1: state_nxt = S_O_D2;
      S_O_D2: state_nxt = (nrn_r == NRN_W'(OUT_CNT - 1)) ? S_H_RD : S_O_D1;
      S_H_RD: state_nxt = S_H_MAC;
      S_H_MAC: state_nxt = (tap_r == last_k) ? S_H_D1 : S_H_RD;
      S_H_D1: state_nxt = S_H_D2;
      S_H_D2: begin
        if (nrn_r == NRN_W'(HID_W - 1) && lay_r == '0) begin
          state_nxt = S_U_RD;
        end else begin
          state_nxt = S_H_RD;
        end
      end
      S_U_RD:  state_nxt = S_U_MUL;
      S_U_MUL: state_nxt = S_U_WR;
      S_U_WR: begin
        if (tap_end && nrn_r == last_nrn && lay_r == LAY_W'(HID_D)) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_U_RD;
        end
      end
      S_FINISH: state_nxt = out_free ? S_IDLE : S_FINISH;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= LR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        lr_r <= cfg_wr_data;
      end
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Counters, accumulator and working values.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r    <= in_if.action;
          lay_r   <= '0;
          nrn_r   <= '0;
          tap_r   <= '0;
          waddr_r <= '0;
          acc_r   <= '0;
          for (int k = 0; k < SCORE_N; k++) tgt_r[k] <= tgt_in[k];
          for (int i = 0; i < IN_CNT; i++) begin
            act_r[i] <= (i < FEAT_N) ? ACT_W'(feat[i < FEAT_N ? i : 0]) : '0;
          end
        end
      end
      S_F_MAC: begin
        acc_r   <= acc_r + prod;
        waddr_r <= WA_W'(waddr_r + 1'b1);
        if (!tap_end) begin
          tap_r <= TAP_W'(tap_r + 1'b1);
        end
      end
      S_F_ACT: begin
        act_r[ACT_IW'((int'(lay_r) + 1) * MAX_N + int'(nrn_r))] <=
          $signed({6'b0, sig_q10(z_net)});
        acc_r <= '0;
        tap_r <= '0;
        if (nrn_r == last_nrn) begin
          nrn_r <= '0;
          if (lay_r != LAY_W'(HID_D)) begin
            lay_r <= LAY_W'(lay_r + 1'b1);
          end
        end else begin
          nrn_r <= NRN_W'(nrn_r + 1'b1);
        end
      end
      S_O_D1: deriv_r <= rnd10_sat(prod);
      S_O_D2: begin
        dlt_r[DLT_IW'(HID_D * MAX_N + int'(nrn_r))] <= rnd10_sat(prod);
        if (nrn_r == NRN_W'(OUT_CNT - 1)) begin
          nrn_r <= '0;
          tap_r <= '0;
          acc_r <= '0;
          lay_r <= LAY_W'(HID_D - 1);
        end else begin
          nrn_r <= NRN_W'(nrn_r + 1'b1);
        end
      end
      S_H_MAC: begin
        acc_r <= acc_r + prod;
        tap_r <= TAP_W'(tap_r + 1'b1);
      end
      S_H_D1: begin
        err_r   <= z_net;
        deriv_r <= rnd10_sat(prod);
        acc_r   <= '0;
        tap_r   <= '0;
      end
      S_H_D2: begin
        dlt_r[DLT_IW'(int'(lay_r) * MAX_N + int'(nrn_r))] <= rnd10_sat(prod);
        if (nrn_r == NRN_W'(HID_W - 1)) begin
          nrn_r <= '0;
          if (lay_r == '0) begin
            waddr_r <= '0;
          end else begin
            lay_r <= LAY_W'(lay_r - 1'b1);
          end
        end else begin
          nrn_r <= NRN_W'(nrn_r + 1'b1);
        end
      end
      S_U_RD:  step_r <= prod[MA_W-1:0];
      S_U_MUL: prod_r <= prod;
      S_U_WR: begin
        waddr_r <= WA_W'(waddr_r + 1'b1);
        if (tap_end) begin
          tap_r <= '0;
          if (nrn_r == last_nrn) begin
            nrn_r <= '0;
            if (lay_r != LAY_W'(HID_D)) begin
              lay_r <= LAY_W'(lay_r + 1'b1);
            end
          end else begin
            nrn_r <= NRN_W'(nrn_r + 1'b1);
          end
        end else begin
          tap_r <= TAP_W'(tap_r + 1'b1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          for (int k = 0; k < SCORE_N; k++) begin
            if (op_r != OP_WRITE && k < OUT_CNT) begin
              score_r[k] <= act_r[(HID_D + 1) * MAX_N + ((k < OUT_CNT) ? k : 0)][Q_W-1:0];
            end else begin
              score_r[k] <= '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.score_a = score_r[0];
  assign out_if.score_b = score_r[1];
  assign out_if.score_c = score_r[2];

endmodule

// ----- hw/rtl/mbt_checker.sv -----
`include "mlp_backprop_trainer_top_defines.svh"

module mbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] score_a,
  input logic [10:0] score_b,
  input logic [10:0] score_c
);
  logic in_take;
  logic out_stall;

  assign in_take   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // A stalled result keeps its values.
  `MBT_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(score_a) && $stable(score_b) && $stable(score_c))

  // Every accepted item takes the block out of the idle state, which drops ready.
  `MBT_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_take, !in_ready)

  // Activations never exceed one.
  `MBT_ASSERT_IMP(a_score_range, clk, rst_n, out_valid, score_a <= 11'd1024 && score_b <= 11'd1024 && score_c <= 11'd1024)

endmodule

bind mlp_backprop_trainer_top mbt_checker u_mbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .score_a   (out_if.score_a),
  .score_b   (out_if.score_b),
  .score_c   (out_if.score_c)
);

// ----- dv/tb_mlp_backprop_trainer_top.sv -----
module tb_mlp_backprop_trainer_top;
  import mbt_pkg::*;

  // Action codes not named in the package.
  localparam logic [1:0] OP_INFER = 2'd0;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RAND_ITEMS = 560;
  localparam int QUIET_TAIL = 120;

  // One input item as offered to the block.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic signed [15:0] fc;
    logic signed [15:0] fd;
    logic [10:0]        ta;
    logic [10:0]        tb;
    logic [10:0]        tc;
    logic [6:0]         widx;
    logic signed [15:0] wval;
  } net_item_t;

  typedef struct packed {
    logic [10:0] sa;
    logic [10:0] sb;
    logic [10:0] sc;
  } score_set_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LR_W-1:0] cfg_wr_data;

  mbt_in_if  in_ch ();
  mbt_out_if out_ch ();

  mlp_backprop_trainer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor state: the weights, the step size and the sigmoid table.
  logic signed [15:0] net_weights [W_TOTAL];
  logic [10:0]        step_size;
  logic [10:0]        sig_rom [256];

  net_item_t  pending_items [$];
  score_set_t expected_scores [$];
  int         mismatches;
  int         scores_seen;
  int         train_count;
  int         infer_count;
  int         write_count;
  bit         quiet_phase;
  bit         hold_sink;
  int         hold_cycles;
  bit         in_fired;

  always #4 clk = ~clk;

  // Sigmoid table from the integer exp recurrence.
  task automatic fill_sig_rom();
    longint unsigned e;
    longint unsigned den;
    e = 64'd1 << 30;
    for (int j = 0; j <= 128; j++) begin
      den = e + (64'd1 << 30);
      if (128 + j < 256) begin
        sig_rom[128 + j] = 11'((64'd1024 * e + den / 2) / den);
      end
      if (j > 0) begin
        sig_rom[128 - j] = 11'(((64'd1 << 40) + den / 2) / den);
      end
      e = (e >> 30) * 64'd1142992222
          + (((e & 64'h3FFF_FFFF) * 64'd1142992222 + (64'd1 << 29)) >> 30);
    end
  endtask

  function automatic longint clamp16(longint v);
    longint r;
    r = v;
    if (v > 32767) r = 32767;
    if (v < -32768) r = -32768;
    return r;
  endfunction

  // Round half up by n bits, floor semantics.
  function automatic longint round_down(longint v, int n);
    longint t;
    t = v + (longint'(1) << (n - 1));
    return t >>> n;
  endfunction

  function automatic longint squash(longint z);
    longint r;
    if (z < -8192) r = sig_rom[0];
    else if (z >= 8192) r = 1024;
    else r = sig_rom[(z + 8192) >>> 6];
    return r;
  endfunction

  function automatic longint slope(longint y);
    return round_down(y * (1024 - y), 10);
  endfunction

  function automatic int fan_of(int layer);
    return (layer == 0) ? IN_CNT : HID_W;
  endfunction

  function automatic int width_of(int layer);
    return (layer == HID_D) ? OUT_CNT : HID_W;
  endfunction

  function automatic int weight_at(int layer, int neuron, int tap);
    int base;
    base = (layer == 0) ? 0 : HBASE + (layer - 1) * HSTRIDE;
    return base + neuron * (fan_of(layer) + 1) + tap;
  endfunction

  // Weight write, or forward pass with an optional SGD step; returns the scores before any update.
  function automatic score_set_t run_network(net_item_t it);
    score_set_t res;
    longint act [HID_D + 2][4];
    longint dlt [HID_D + 1][4];
    longint acc;
    longint err;
    longint stp;
    longint a;
    longint tgt [3];
    int fi;
    int w;
    res = '0;
    if (it.action == OP_WRITE) begin
      if (it.widx < W_TOTAL) net_weights[it.widx] = it.wval;
      return res;
    end
    act[0][0] = it.fa;
    act[0][1] = it.fb;
    act[0][2] = it.fc;
    act[0][3] = it.fd;
    for (int l = 0; l <= HID_D; l++) begin
      fi = fan_of(l);
      for (int i = 0; i < width_of(l); i++) begin
        acc = longint'(net_weights[weight_at(l, i, fi)]) * 1024;
        for (int j = 0; j < fi; j++) begin
          acc += longint'(net_weights[weight_at(l, i, j)]) * act[l][j];
        end
        act[l + 1][i] = squash(clamp16(round_down(acc, 10)));
      end
    end
    res.sa = 11'(act[HID_D + 1][0]);
    res.sb = 11'(act[HID_D + 1][1]);
    res.sc = 11'(act[HID_D + 1][2]);
    if (it.action != OP_TRAIN) return res;
    tgt[0] = it.ta;
    tgt[1] = it.tb;
    tgt[2] = it.tc;
    for (int k = 0; k < OUT_CNT; k++) begin
      dlt[HID_D][k] = clamp16(round_down((tgt[k] - act[HID_D + 1][k])
                                         * slope(act[HID_D + 1][k]), 10));
    end
    for (int l = HID_D - 1; l >= 0; l--) begin
      for (int j = 0; j < HID_W; j++) begin
        acc = 0;
        for (int k = 0; k < width_of(l + 1); k++) begin
          acc += dlt[l + 1][k] * longint'(net_weights[weight_at(l + 1, k, j)]);
        end
        err = clamp16(round_down(acc, 10));
        dlt[l][j] = clamp16(round_down(err * slope(act[l + 1][j]), 10));
      end
    end
    for (int l = 0; l <= HID_D; l++) begin
      fi = fan_of(l);
      for (int i = 0; i < width_of(l); i++) begin
        stp = longint'(step_size) * dlt[l][i];
        for (int j = 0; j <= fi; j++) begin
          a = (j < fi) ? act[l][j] : 1024;
          w = weight_at(l, i, j);
          net_weights[w] = 16'(clamp16(longint'(net_weights[w]) + round_down(stp * a, 20)));
        end
      end
    end
    return res;
  endfunction

  function automatic net_item_t rand_item(logic [1:0] op, int spread);
    net_item_t it;
    it.action = op;
    it.fa = 16'($urandom_range(0, 2 * spread) - spread);
    it.fb = 16'($urandom_range(0, 2 * spread) - spread);
    it.fc = 16'($urandom_range(0, 2 * spread) - spread);
    it.fd = 16'($urandom_range(0, 2 * spread) - spread);
    it.ta = 11'($urandom_range(0, 1024));
    it.tb = 11'($urandom_range(0, 1024));
    it.tc = 11'($urandom_range(0, 1024));
    it.widx = 7'($urandom_range(0, W_TOTAL - 1));
    it.wval = 16'($urandom_range(0, 2 * spread) - spread);
    return it;
  endfunction

  // Wait for the block to drain, then let trailing work settle before a write.
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_scores.size() != 0 || in_ch.valid) begin
      @(posedge clk);
    end
    repeat (QUIET_TAIL) @(posedge clk);
  endtask

  task automatic set_step(logic [10:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    step_size = v;
  endtask

  // Sender: offers queued items with random gap bursts.
  int send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
      in_fired = 1'b0;
    end else if (in_ch.valid && !in_fired) begin
      // Hold the item until it is taken.
    end else begin
      in_fired = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        net_item_t it;
        it = pending_items.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.action       <= it.action;
        in_ch.feature_a    <= it.fa;
        in_ch.feature_b    <= it.fb;
        in_ch.feature_c    <= it.fc;
        in_ch.feature_d    <= it.fd;
        in_ch.target_a     <= it.ta;
        in_ch.target_b     <= it.tb;
        in_ch.target_c     <= it.tc;
        in_ch.weight_index <= it.widx;
        in_ch.weight_value <= it.wval;
        if (!quiet_phase && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold when requested.
  int sink_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet_phase && !hold_sink && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 15) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Accepted input items feed the predictor.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      net_item_t it;
      in_fired  = 1'b1;
      it.action = in_ch.action;
      it.fa     = in_ch.feature_a;
      it.fb     = in_ch.feature_b;
      it.fc     = in_ch.feature_c;
      it.fd     = in_ch.feature_d;
      it.ta     = in_ch.target_a;
      it.tb     = in_ch.target_b;
      it.tc     = in_ch.target_c;
      it.widx   = in_ch.weight_index;
      it.wval   = in_ch.weight_value;
      case (it.action)
        OP_TRAIN: train_count++;
        OP_WRITE: write_count++;
        default: infer_count++;
      endcase
      expected_scores.push_back(run_network(it));
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      score_set_t exp_s;
      scores_seen++;
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h %h %h",
                                       out_ch.score_a, out_ch.score_b, out_ch.score_c);
      end else begin
        exp_s = expected_scores.pop_front();
        if (exp_s.sa !== out_ch.score_a || exp_s.sb !== out_ch.score_b ||
            exp_s.sc !== out_ch.score_c) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("score mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     exp_s.sa, exp_s.sb, exp_s.sc,
                     out_ch.score_a, out_ch.score_b, out_ch.score_c);
          end
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    net_item_t it;
    int burst;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.feature_a = '0;
    in_ch.feature_b = '0;
    in_ch.feature_c = '0;
    in_ch.feature_d = '0;
    in_ch.target_a = '0;
    in_ch.target_b = '0;
    in_ch.target_c = '0;
    in_ch.weight_index = '0;
    in_ch.weight_value = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    scores_seen = 0;
    train_count = 0;
    infer_count = 0;
    write_count = 0;
    quiet_phase = 1'b0;
    hold_sink = 1'b0;
    hold_cycles = 0;
    in_fired = 1'b0;
    step_size = LR_RESET;
    foreach (net_weights[i]) net_weights[i] = '0;
    fill_sig_rom();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero network, extremes of features and targets, every action.
    it = '0;
    it.action = OP_INFER;
    pending_items.push_back(it);
    it.action = OP_TRAIN;
    it.fa = 16'sh7FFF; it.fb = 16'sh8000; it.fc = 16'sh7FFF; it.fd = 16'sh8000;
    it.ta = 11'h7FF; it.tb = 11'd0; it.tc = 11'd1024;
    pending_items.push_back(it);
    it.action = OP_SPARE;
    pending_items.push_back(it);
    for (int k = 0; k < 6; k++) begin
      it = rand_item(OP_WRITE, 32768);
      it.widx = 7'(k * 14);
      it.wval = (k % 2) ? 16'sh8000 : 16'sh7FFF;
      pending_items.push_back(it);
    end
    it = rand_item(OP_WRITE, 100);
    it.widx = 7'(W_TOTAL);
    pending_items.push_back(it);
    it.widx = 7'h7F;
    it.wval = 16'shFFFF;
    pending_items.push_back(it);
    it = rand_item(OP_INFER, 32768);
    pending_items.push_back(it);
    it = rand_item(OP_TRAIN, 32768);
    it.ta = 11'h7FF; it.tb = 11'h7FF; it.tc = 11'h7FF;
    pending_items.push_back(it);
    wait_drained();

    // Step-size extremes, including values above one.
    set_step(11'd0);
    for (int k = 0; k < 3; k++) pending_items.push_back(rand_item(OP_TRAIN, 4096));
    wait_drained();
    set_step(11'h7FF);
    for (int k = 0; k < 3; k++) pending_items.push_back(rand_item(OP_TRAIN, 4096));
    wait_drained();
    set_step(11'd1024);

    // Long receiver hold while the sender keeps offering.
    for (int k = 0; k < 8; k++) pending_items.push_back(rand_item(OP_INFER, 2048));
    hold_cycles = 3000;
    wait_drained();

    // Random phases: load a network, then a mix of training, inference and writes on it.
    for (int ph = 0; ph < 8; ph++) begin
      set_step(11'($urandom_range(0, 2047)));
      for (int k = 0; k < W_TOTAL; k += $urandom_range(1, 4)) begin
        it = rand_item(OP_WRITE, (ph % 3 == 0) ? 32768 : 2048);
        it.widx = 7'(k);
        pending_items.push_back(it);
      end
      if (ph == 7) quiet_phase = 1'b1;
      burst = 0;
      while (burst < RAND_ITEMS / 8) begin
        case ($urandom_range(0, 9))
          0: it = rand_item(OP_WRITE, 32768);
          1: it = rand_item(2'($urandom_range(0, 3)), 32768);
          2, 3, 4: it = rand_item(OP_INFER, 4096);
          default: it = rand_item(OP_TRAIN, 4096);
        endcase
        if ($urandom_range(0, 15) == 0) it.widx = 7'($urandom_range(0, 127));
        pending_items.push_back(it);
        burst++;
      end
      wait_drained();
    end

    $display("covered %0d inferences, %0d training steps and %0d weight writes",
             infer_count, train_count, write_count);
    $display("%0d results checked over several step sizes", scores_seen);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
